### sv/wpd_pkg.sv
`timescale 1ns / 1ps

package wpd_pkg;

    localparam int NUM_RESIDUES = 20;
    localparam int IDX_W        = 5;
    localparam int ROM_SLOTS    = 1 << IDX_W;
    localparam int PROP_W       = 16;
    localparam int ALPHA_W      = 32;
    localparam int DIST_W       = 24;

    typedef struct packed {
        logic [IDX_W-1:0] first_residue;
        logic [IDX_W-1:0] second_residue;
    } t_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              index_error;
    } t_result;

    // default property tables, unsigned Q8.8; unused slots read as zero
    localparam logic [PROP_W-1:0] COMP_ROM [ROM_SLOTS] = '{
        16'd0,   16'd166, 16'd340, 16'd353, 16'd704, 16'd228, 16'd236, 16'd189,
        16'd148, 16'd0,   16'd0,   16'd84,  16'd0,   16'd0,   16'd100, 16'd364,
        16'd182, 16'd33,  16'd51,  16'd0,   16'd0,   16'd0,   16'd0,   16'd0,
        16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0
    };

    localparam logic [PROP_W-1:0] POL_ROM [ROM_SLOTS] = '{
        16'd2074, 16'd2688, 16'd2970, 16'd3328, 16'd1408, 16'd2688, 16'd3149, 16'd2304,
        16'd2662, 16'd1331, 16'd1254, 16'd2893, 16'd1459, 16'd1331, 16'd2048, 16'd2355,
        16'd2202, 16'd1382, 16'd1587, 16'd1510, 16'd0,    16'd0,    16'd0,    16'd0,
        16'd0,    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,    16'd0
    };

    localparam logic [PROP_W-1:0] VOL_ROM [ROM_SLOTS] = '{
        16'd7936,  16'd31744, 16'd14336, 16'd13824, 16'd14080, 16'd21760, 16'd21248,
        16'd768,   16'd24576, 16'd28416, 16'd28416, 16'd30464, 16'd26880, 16'd33792,
        16'd8320,  16'd8192,  16'd15616, 16'd43520, 16'd34816, 16'd21504, 16'd0,
        16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0,
        16'd0,     16'd0,     16'd0,     16'd0
    };

endpackage

### sv/weighted_property_distance.sv
`timescale 1ns / 1ps

// An accepted item passes the lookup, difference, square, weighting, sum and root registers, then the output register.
// Throughput: one item per cycle; busy stays low, the pipe never backs up.
// Depth is set by the square root: one result bit per stage, 21 stages, after the
// lookup, difference, square, weighting and sum stages.
// Reset (synchronous, i_rst_n low) clears the valid bits and zeroes all three alphas.
module weighted_property_distance (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  wpd_pkg::t_item      i_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output logic                o_result_valid,
    output wpd_pkg::t_result    o_result
);
    import wpd_pkg::*;

    localparam logic [1:0] CFG_ALPHA_COMP = 2'd0;
    localparam logic [1:0] CFG_ALPHA_POL  = 2'd1;
    localparam logic [1:0] CFG_ALPHA_VOL  = 2'd2;

    localparam int SQ_W     = 2 * PROP_W;
    localparam int PROD_W   = SQ_W + ALPHA_W;
    localparam int FRAC_CUT = 24;
    localparam int WSQ_W    = PROD_W - FRAC_CUT;
    localparam int SUM_W    = WSQ_W + 2;
    localparam int SQ_STEPS = SUM_W / 2;
    localparam int Q_W      = SQ_STEPS;
    localparam int REM_W    = Q_W + 4;

    logic [ALPHA_W-1:0] r_alpha_comp, r_alpha_pol, r_alpha_vol;
    logic               accept;

    // stage 1: table lookup
    logic              r_s1_v, r_s1_err;
    logic [PROP_W-1:0] r_s1_ca, r_s1_cb, r_s1_pa, r_s1_pb, r_s1_va, r_s1_vb;
    // stage 2: absolute differences
    logic              r_s2_v, r_s2_err;
    logic [PROP_W-1:0] r_s2_dc, r_s2_dp, r_s2_dv;
    // stage 3: squares
    logic              r_s3_v, r_s3_err;
    logic [SQ_W-1:0]   r_s3_sc, r_s3_sp, r_s3_sv;
    // stage 4: weighted squares, Q24.16
    logic              r_s4_v, r_s4_err;
    logic [WSQ_W-1:0]  r_s4_wc, r_s4_wp, r_s4_wv;
    logic [PROD_W-1:0] prod_c, prod_p, prod_v;

    // square-root stages; entry 0 is the sum stage
    logic              r_sq_v   [SQ_STEPS+1];
    logic              r_sq_err [SQ_STEPS+1];
    logic [Q_W-1:0]    r_q      [SQ_STEPS+1];
    logic [REM_W-1:0]  r_rem    [SQ_STEPS+1];
    logic [SUM_W-1:0]  r_rad    [SQ_STEPS+1];
    logic [Q_W-1:0]    n_q      [SQ_STEPS+1];
    logic [REM_W-1:0]  n_rem    [SQ_STEPS+1];
    logic [SUM_W-1:0]  n_rad    [SQ_STEPS+1];
    logic [REM_W-1:0]  rem_sh   [SQ_STEPS];
    logic [REM_W-1:0]  trial    [SQ_STEPS];

    logic              s0_err;
    logic [Q_W:0]      rounded;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign s0_err = ({1'b0, i_item.first_residue}  >= (IDX_W+1)'(NUM_RESIDUES))
                 || ({1'b0, i_item.second_residue} >= (IDX_W+1)'(NUM_RESIDUES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_comp <= '0;
            r_alpha_pol  <= '0;
            r_alpha_vol  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALPHA_COMP: r_alpha_comp <= i_cfg_data;
                CFG_ALPHA_POL:  r_alpha_pol  <= i_cfg_data;
                CFG_ALPHA_VOL:  r_alpha_vol  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign prod_c = PROD_W'(r_s3_sc) * PROD_W'(r_alpha_comp);
    assign prod_p = PROD_W'(r_s3_sp) * PROD_W'(r_alpha_pol);
    assign prod_v = PROD_W'(r_s3_sv) * PROD_W'(r_alpha_vol);

    // restoring square root, two radicand bits in and one root bit out per stage
    always_comb begin
        n_q[0]   = '0;
        n_rem[0] = '0;
        n_rad[0] = '0;
        for (int s = 0; s < SQ_STEPS; s++) begin
            rem_sh[s]  = {r_rem[s][REM_W-3:0], r_rad[s][SUM_W-1 -: 2]};
            trial[s]   = REM_W'({r_q[s], 2'b01});
            n_rad[s+1] = {r_rad[s][SUM_W-3:0], 2'b00};
            if (rem_sh[s] >= trial[s]) begin
                n_rem[s+1] = rem_sh[s] - trial[s];
                n_q[s+1]   = {r_q[s][Q_W-2:0], 1'b1};
            end else begin
                n_rem[s+1] = rem_sh[s];
                n_q[s+1]   = {r_q[s][Q_W-2:0], 1'b0};
            end
        end
    end

    // round to nearest: remainder above root means past the half step.
    // root stays below 2^21, so the 24-bit clamp never bites.
    assign rounded = (r_rem[SQ_STEPS] > REM_W'(r_q[SQ_STEPS]))
                   ? ((Q_W+1)'(r_q[SQ_STEPS]) + (Q_W+1)'(1))
                   : (Q_W+1)'(r_q[SQ_STEPS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v         <= 1'b0;
            r_s2_v         <= 1'b0;
            r_s3_v         <= 1'b0;
            r_s4_v         <= 1'b0;
            o_result_valid <= 1'b0;
            for (int s = 0; s <= SQ_STEPS; s++) begin
                r_sq_v[s] <= 1'b0;
            end
        end else begin
            r_s1_v         <= accept;
            r_s2_v         <= r_s1_v;
            r_s3_v         <= r_s2_v;
            r_s4_v         <= r_s3_v;
            r_sq_v[0]      <= r_s4_v;
            for (int s = 0; s < SQ_STEPS; s++) begin
                r_sq_v[s+1] <= r_sq_v[s];
            end
            o_result_valid <= r_sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_err <= s0_err;
        r_s1_ca  <= COMP_ROM[i_item.first_residue];
        r_s1_cb  <= COMP_ROM[i_item.second_residue];
        r_s1_pa  <= POL_ROM[i_item.first_residue];
        r_s1_pb  <= POL_ROM[i_item.second_residue];
        r_s1_va  <= VOL_ROM[i_item.first_residue];
        r_s1_vb  <= VOL_ROM[i_item.second_residue];

        r_s2_err <= r_s1_err;
        r_s2_dc  <= (r_s1_ca > r_s1_cb) ? r_s1_ca - r_s1_cb : r_s1_cb - r_s1_ca;
        r_s2_dp  <= (r_s1_pa > r_s1_pb) ? r_s1_pa - r_s1_pb : r_s1_pb - r_s1_pa;
        r_s2_dv  <= (r_s1_va > r_s1_vb) ? r_s1_va - r_s1_vb : r_s1_vb - r_s1_va;

        r_s3_err <= r_s2_err;
        r_s3_sc  <= SQ_W'(r_s2_dc) * SQ_W'(r_s2_dc);
        r_s3_sp  <= SQ_W'(r_s2_dp) * SQ_W'(r_s2_dp);
        r_s3_sv  <= SQ_W'(r_s2_dv) * SQ_W'(r_s2_dv);

        r_s4_err <= r_s3_err;
        r_s4_wc  <= prod_c[PROD_W-1:FRAC_CUT];
        r_s4_wp  <= prod_p[PROD_W-1:FRAC_CUT];
        r_s4_wv  <= prod_v[PROD_W-1:FRAC_CUT];

        r_sq_err[0] <= r_s4_err;
        r_q[0]      <= n_q[0];
        r_rem[0]    <= n_rem[0];
        r_rad[0]    <= SUM_W'(r_s4_wc) + SUM_W'(r_s4_wp) + SUM_W'(r_s4_wv);
        for (int s = 0; s < SQ_STEPS; s++) begin
            r_sq_err[s+1] <= r_sq_err[s];
            r_q[s+1]      <= n_q[s+1];
            r_rem[s+1]    <= n_rem[s+1];
            r_rad[s+1]    <= n_rad[s+1];
        end

        o_result.index_error <= r_sq_err[SQ_STEPS];
        o_result.distance    <= r_sq_err[SQ_STEPS] ? '0 : DIST_W'(rounded);
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.index_error |-> o_result.distance == '0)
        else $error("index error result with nonzero distance");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_v[SQ_STEPS] |-> r_rem[SQ_STEPS] <= REM_W'({r_q[SQ_STEPS], 1'b0}))
        else $error("square root remainder exceeds twice the root");

    a_root_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_v[SQ_STEPS] |=> o_result_valid)
        else $error("finished root did not reach the output");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !$past(r_sq_v[SQ_STEPS]) |-> $past(!i_rst_n))
        else $error("result strobe without an item behind it");

endmodule

### tb/weighted_property_distance_tb.sv
`timescale 1ns / 1ps

module weighted_property_distance_tb;
    import wpd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 200;
    localparam int RAND_ITEMS  = 460;

    typedef enum logic [1:0] {
        REG_ALPHA_COMP = 2'd0,
        REG_ALPHA_POL  = 2'd1,
        REG_ALPHA_VOL  = 2'd2,
        REG_SPARE      = 2'd3
    } t_reg_index;

    // property tables, unsigned Q8.8, one entry per valid residue
    localparam logic [15:0] COMP_TAB [20] = '{
        16'd0,   16'd166, 16'd340, 16'd353, 16'd704, 16'd228, 16'd236, 16'd189, 16'd148, 16'd0,
        16'd0,   16'd84,  16'd0,   16'd0,   16'd100, 16'd364, 16'd182, 16'd33,  16'd51,  16'd0
    };
    localparam logic [15:0] POL_TAB [20] = '{
        16'd2074, 16'd2688, 16'd2970, 16'd3328, 16'd1408, 16'd2688, 16'd3149, 16'd2304,
        16'd2662, 16'd1331, 16'd1254, 16'd2893, 16'd1459, 16'd1331, 16'd2048, 16'd2355,
        16'd2202, 16'd1382, 16'd1587, 16'd1510
    };
    localparam logic [15:0] VOL_TAB [20] = '{
        16'd7936,  16'd31744, 16'd14336, 16'd13824, 16'd14080, 16'd21760, 16'd21248,
        16'd768,   16'd24576, 16'd28416, 16'd28416, 16'd30464, 16'd26880, 16'd33792,
        16'd8320,  16'd8192,  16'd15616, 16'd43520, 16'd34816, 16'd21504
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_result_valid;
    t_result     o_result;

    t_item       pair_queue[$];
    t_result     dist_expected[$];
    logic [31:0] w_comp, w_pol, w_vol;
    int          send_gap_pct;
    int          errors;
    int          cycles;
    logic        taken;

    weighted_property_distance dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [63:0] weighted_term(logic [15:0] a, logic [15:0] b,
                                                  logic [31:0] w);
        logic [63:0] d;
        d = (a > b) ? 64'(a - b) : 64'(b - a);
        return (d * d * 64'(w)) >> 24;
    endfunction

    // integer square root, rounded to nearest
    function automatic logic [63:0] rounded_root(logic [63:0] v);
        logic [63:0] rem, root, bitv;
        rem  = v;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        if (v - root * root > root)
            root = root + 1;
        return root;
    endfunction

    function automatic t_result grantham_distance(t_item it);
        t_result     r;
        logic [63:0] sum, root;
        int          a, b;
        a = it.first_residue;
        b = it.second_residue;
        r = '0;
        if (a >= NUM_RESIDUES || b >= NUM_RESIDUES) begin
            r.index_error = 1'b1;
            return r;
        end
        sum = weighted_term(COMP_TAB[a], COMP_TAB[b], w_comp)
            + weighted_term(POL_TAB[a], POL_TAB[b], w_pol)
            + weighted_term(VOL_TAB[a], VOL_TAB[b], w_vol);
        root = rounded_root(sum);
        r.distance = (root > 64'hFFFFFF) ? 24'hFFFFFF : root[23:0];
        return r;
    endfunction

    // driver: a new item goes out only once the previous one has been taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || taken) begin
            if (pair_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                i_item <= pair_queue.pop_front();
                start  <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("weighted_property_distance_tb: errors");
            $finish;
        end
        taken <= 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                dist_expected.push_back(grantham_distance(i_item));
                taken <= 1'b1;
            end
            if (o_result_valid) begin
                if (dist_expected.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result: distance %0d err %0b",
                                 o_result.distance, o_result.index_error);
                    errors++;
                end else begin
                    want = dist_expected.pop_front();
                    if (o_result.distance !== want.distance
                            || o_result.index_error !== want.index_error) begin
                        if (errors < 10)
                            $display("mismatch: expected distance %0d err %0b, got %0d err %0b",
                                     want.distance, want.index_error,
                                     o_result.distance, o_result.index_error);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_reg(t_reg_index idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_ALPHA_COMP: w_comp = data;
            REG_ALPHA_POL:  w_pol  = data;
            REG_ALPHA_VOL:  w_vol  = data;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (pair_queue.size() != 0 || start || dist_expected.size() != 0);
    endtask

    task automatic push_pair(int a, int b);
        t_item it;
        it.first_residue  = IDX_W'(a);
        it.second_residue = IDX_W'(b);
        pair_queue.push_back(it);
    endtask

    task automatic push_directed();
        push_pair(0, 0);
        push_pair(19, 19);
        push_pair(0, 19);
        push_pair(19, 0);
        push_pair(7, 17);    // widest volume gap
        push_pair(4, 0);     // widest composition gap
        push_pair(3, 10);    // widest polarity gap
        push_pair(20, 0);    // first index just out of range
        push_pair(0, 20);
        push_pair(31, 31);
        push_pair(31, 5);
        push_pair(19, 20);
    endtask

    function automatic logic [31:0] pick_alpha();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0100_0000;    // 1.0
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int    gap_modes [4];
        t_item it;
        int    waited;
        gap_modes    = '{0, 60, 0, 13};
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_ALPHA_COMP;
        i_cfg_data   = '0;
        w_comp       = '0;
        w_pol        = '0;
        w_vol        = '0;
        send_gap_pct = 0;
        errors       = 0;
        cycles       = 0;
        taken        = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // alphas still at reset
        push_directed();
        wait_drained();

        write_reg(REG_ALPHA_COMP, 32'hFFFF_FFFF);
        write_reg(REG_ALPHA_POL, 32'hFFFF_FFFF);
        write_reg(REG_ALPHA_VOL, 32'hFFFF_FFFF);
        write_reg(REG_SPARE, 32'h0000_0000);      // no such register, must be ignored
        end_writes();
        push_directed();
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_ALPHA_COMP, pick_alpha());
            write_reg(REG_ALPHA_POL, pick_alpha());
            write_reg(REG_ALPHA_VOL, pick_alpha());
            write_reg(REG_SPARE, $urandom);
            end_writes();
            send_gap_pct = gap_modes[ph];
            for (int n = 0; n < RAND_ITEMS; n++) begin
                // mostly valid residues; the rest spans the whole index field
                if ($urandom_range(99) < 85) begin
                    it.first_residue  = IDX_W'($urandom_range(NUM_RESIDUES - 1));
                    it.second_residue = IDX_W'($urandom_range(NUM_RESIDUES - 1));
                end else begin
                    it.first_residue  = IDX_W'($urandom);
                    it.second_residue = IDX_W'($urandom);
                end
                pair_queue.push_back(it);
            end
            wait_drained();
        end

        // any result still outstanding after the drain window is lost
        waited = 0;
        while (dist_expected.size() != 0 && waited < DRAIN_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (dist_expected.size() != 0)
            errors += dist_expected.size();
        if (errors == 0) begin
            $display("weighted_property_distance_tb: clean");
        end else begin
            $display("weighted_property_distance_tb: errors");
        end
        $finish;
    end

endmodule
